// ===== rtl/core/serial_rgb_command_line_parser_core_assert.svh =====
// assertion macros used by the parser core checker
`ifndef SERIAL_RGB_COMMAND_LINE_PARSER_CORE_ASSERT_SVH
`define SERIAL_RGB_COMMAND_LINE_PARSER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SRGB_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srgb port check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define SRGB_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srgb port check failed");

`endif

// ===== rtl/core/srgb_pkg.sv =====
// shared constants, types and helper functions of the rgb command line parser
`timescale 1ns / 1ps

package srgb_pkg;

    localparam int LINE_DEPTH = 128;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int LEN_W      = $clog2(LINE_DEPTH + 1);
    localparam int TDATA_W    = 32;

    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] CH_BS = 8'd127;

    localparam logic       KIND_ECHO = 1'b0;
    localparam logic       KIND_LINE = 1'b1;

    localparam logic [1:0] CHAN_NONE  = 2'd0;
    localparam logic [1:0] CHAN_RED   = 2'd1;
    localparam logic [1:0] CHAN_GREEN = 2'd2;
    localparam logic [1:0] CHAN_BLUE  = 2'd3;

    // one result beat before packing onto the bus
    typedef struct packed {
        logic       kind;
        logic [7:0] echo;
        logic [1:0] chan;
        logic [15:0] level;
        logic       ovf;
    } srgb_result_t;

    // parser status seen by the walk control
    typedef struct packed {
        logic        stop;
        logic [1:0]  chan;
        logic [15:0] value;
    } srgb_parse_status_t;

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= "0") && (c <= "9");
    endfunction

    // channel picked by the first letter of the line
    function automatic logic [1:0] kw_pick(input logic [7:0] c);
        case (c)
            "r":     kw_pick = CHAN_RED;
            "g":     kw_pick = CHAN_GREEN;
            "b":     kw_pick = CHAN_BLUE;
            default: kw_pick = CHAN_NONE;
        endcase
    endfunction

    function automatic logic [2:0] kw_len(input logic [1:0] kw);
        case (kw)
            CHAN_RED:   kw_len = 3'd3;
            CHAN_GREEN: kw_len = 3'd5;
            CHAN_BLUE:  kw_len = 3'd4;
            default:    kw_len = 3'd0;
        endcase
    endfunction

    function automatic logic [7:0] kw_char(input logic [1:0] kw, input logic [2:0] idx);
        logic [7:0] c;
        c = 8'h00;
        case (kw)
            CHAN_RED:
            begin
                case (idx)
                    3'd0:    c = "r";
                    3'd1:    c = "e";
                    3'd2:    c = "d";
                    default: c = 8'h00;
                endcase
            end
            CHAN_GREEN:
            begin
                case (idx)
                    3'd0:    c = "g";
                    3'd1:    c = "r";
                    3'd2:    c = "e";
                    3'd3:    c = "e";
                    3'd4:    c = "n";
                    default: c = 8'h00;
                endcase
            end
            CHAN_BLUE:
            begin
                case (idx)
                    3'd0:    c = "b";
                    3'd1:    c = "l";
                    3'd2:    c = "u";
                    3'd3:    c = "e";
                    default: c = 8'h00;
                endcase
            end
            default: c = 8'h00;
        endcase
        kw_char = c;
    endfunction

endpackage

// ===== rtl/core/srgb_line_ram.sv =====
// simple dual port line store, registered read
`timescale 1ns / 1ps

module srgb_line_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/srgb_parser.sv =====
// character-at-a-time matcher for the red / green / blue commands
`timescale 1ns / 1ps

module srgb_parser (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         step,
    input  logic [7:0]                   char_in,
    output srgb_pkg::srgb_parse_status_t status
);

    typedef enum logic [2:0] {
        P_KW,
        P_WS,
        P_SIGN,
        P_DIG,
        P_STOP
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  kw_reg, kw_next;
    logic [2:0]  idx_reg, idx_next;
    logic        any_reg, any_next;
    logic [15:0] acc_reg, acc_next;
    logic        stop;
    logic [15:0] digit;

    assign digit = {12'd0, 4'(char_in - "0")};

    always_comb
    begin
        phase_next = phase_reg;
        kw_next    = kw_reg;
        idx_next   = idx_reg;
        any_next   = any_reg;
        acc_next   = acc_reg;
        stop       = 1'b0;
        if (start)
        begin
            phase_next = P_KW;
            kw_next    = srgb_pkg::CHAN_NONE;
            idx_next   = 3'd0;
            any_next   = 1'b0;
            acc_next   = 16'd0;
        end
        else if (step)
        begin
            case (phase_reg)
                P_KW:
                begin
                    if (idx_reg == 3'd0)
                    begin
                        kw_next  = srgb_pkg::kw_pick(char_in);
                        idx_next = 3'd1;
                        if (srgb_pkg::kw_pick(char_in) == srgb_pkg::CHAN_NONE)
                        begin
                            stop       = 1'b1;
                            phase_next = P_STOP;
                        end
                    end
                    else if (char_in == srgb_pkg::kw_char(kw_reg, idx_reg))
                    begin
                        idx_next = 3'(idx_reg + 3'd1);
                        if (3'(idx_reg + 3'd1) == srgb_pkg::kw_len(kw_reg))
                        begin
                            phase_next = P_WS;
                        end
                    end
                    else
                    begin
                        stop       = 1'b1;
                        phase_next = P_STOP;
                    end
                end
                P_WS:
                begin
                    // sign is accepted but a square does not depend on it
                    if (srgb_pkg::is_space(char_in))
                    begin
                        phase_next = P_WS;
                    end
                    else if ((char_in == "+") || (char_in == "-"))
                    begin
                        phase_next = P_SIGN;
                    end
                    else if (srgb_pkg::is_digit(char_in))
                    begin
                        acc_next   = digit;
                        any_next   = 1'b1;
                        phase_next = P_DIG;
                    end
                    else
                    begin
                        stop       = 1'b1;
                        phase_next = P_STOP;
                    end
                end
                P_SIGN:
                begin
                    if (srgb_pkg::is_digit(char_in))
                    begin
                        acc_next   = digit;
                        any_next   = 1'b1;
                        phase_next = P_DIG;
                    end
                    else
                    begin
                        stop       = 1'b1;
                        phase_next = P_STOP;
                    end
                end
                P_DIG:
                begin
                    if (srgb_pkg::is_digit(char_in))
                    begin
                        // acc * 10 + digit, wrapping at 16 bits
                        acc_next = 16'({acc_reg[12:0], 3'b000} + {acc_reg[14:0], 1'b0} + digit);
                    end
                    else
                    begin
                        stop       = 1'b1;
                        phase_next = P_STOP;
                    end
                end
                P_STOP:
                begin
                    stop = 1'b1;
                end
                default:
                begin
                    stop       = 1'b1;
                    phase_next = P_STOP;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_STOP;
            kw_reg    <= srgb_pkg::CHAN_NONE;
            idx_reg   <= 3'd0;
            any_reg   <= 1'b0;
            acc_reg   <= 16'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            kw_reg    <= kw_next;
            idx_reg   <= idx_next;
            any_reg   <= any_next;
            acc_reg   <= acc_next;
        end
    end

    assign status.stop  = stop;
    assign status.chan  = any_reg ? kw_reg : srgb_pkg::CHAN_NONE;
    assign status.value = acc_reg;

endmodule

// ===== rtl/core/serial_rgb_command_line_parser_core.sv =====
// top level: line editing, line store walk and result output of the rgb command parser
`timescale 1ns / 1ps
// ordinary byte: echo beat loaded into the skid stage, which drains into the output register;
//   the next byte is taken once the skid stage has drained
// carriage return: the walk reads one store byte per cycle through the registered ram
//   read to the end or until the matcher stops; S_FINISH then loads the skid stage
// input waits in S_WALK and S_FINISH and while the skid stage is full (output stalled)
// reset clears line length, overflow flag and handshake state; line store not cleared

module serial_rgb_command_line_parser_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] rx_byte
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [srgb_pkg::TDATA_W-1:0] m_tdata,  // [7:0] echo_char, [9:8] led_channel,
                                                   // [25:10] pwm_level, [26] line_overflowed
    output logic [0:0]                  m_tuser    // [0] result_kind
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FINISH
    } state_t;

    localparam int ADDR_W = srgb_pkg::ADDR_W;
    localparam int LEN_W  = srgb_pkg::LEN_W;

    state_t                  state_reg, state_next;
    logic [LEN_W-1:0]        len_reg, len_next;        // stored line length
    logic                    ovf_reg, ovf_next;        // byte dropped in this line
    logic [LEN_W-1:0]        issue_reg, issue_next;    // next store address to read
    logic                    dvld_reg, dvld_next;      // ram read data is a line byte
    logic                    pend_valid_reg, pend_valid_next;
    srgb_pkg::srgb_result_t  pend_reg, pend_next;      // skid stage ahead of the output
    logic                    out_valid_reg, out_valid_next;
    srgb_pkg::srgb_result_t  out_reg, out_next;

    logic                    accept;
    logic                    is_cr;
    logic                    is_bs;
    logic                    store_byte;
    logic                    walk_step;
    logic                    walk_issue;
    logic [7:0]              rd_data;
    logic [31:0]             square_full;
    srgb_pkg::srgb_parse_status_t status;

    // take a byte only while idle with the skid stage empty
    assign s_tready   = (state_reg == S_IDLE) && !pend_valid_reg;
    assign accept     = s_tvalid && s_tready;
    assign is_cr      = (s_tdata == srgb_pkg::CH_CR);
    assign is_bs      = (s_tdata == srgb_pkg::CH_BS);
    assign store_byte = accept && !is_cr && !is_bs
                        && (len_reg < LEN_W'(srgb_pkg::LINE_DEPTH));

    // walk: read one address per cycle, feed the previous read into the matcher
    assign walk_step  = (state_reg == S_WALK) && dvld_reg;
    assign walk_issue = (state_reg == S_WALK) && (issue_reg < len_reg)
                        && !(walk_step && status.stop);

    srgb_line_ram #(
        .DEPTH (srgb_pkg::LINE_DEPTH),
        .WIDTH (8)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (store_byte),
        .wr_addr (len_reg[ADDR_W-1:0]),
        .wr_data (s_tdata),
        .rd_en   (walk_issue),
        .rd_addr (issue_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    srgb_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept && is_cr),
        .step    (walk_step),
        .char_in (rd_data),
        .status  (status)
    );

    // level = value squared mod 65536, from the matcher's registered value
    assign square_full = status.value * status.value;

    always_comb
    begin
        state_next      = state_reg;
        len_next        = len_reg;
        ovf_next        = ovf_reg;
        issue_next      = issue_reg;
        dvld_next       = 1'b0;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;

        // skid stage drains into the output register
        if (pend_valid_reg && (!out_valid_reg || m_tready))
        begin
            out_next        = pend_reg;
            out_valid_next  = 1'b1;
            pend_valid_next = 1'b0;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (is_cr)
                    begin
                        state_next = S_WALK;
                        issue_next = '0;
                    end
                    else if (is_bs)
                    begin
                        // backspace at an empty line does nothing
                        if (len_reg != '0)
                        begin
                            len_next = LEN_W'(len_reg - 1'b1);
                        end
                    end
                    else if (store_byte)
                    begin
                        len_next              = LEN_W'(len_reg + 1'b1);
                        pend_valid_next       = 1'b1;
                        pend_next.kind        = srgb_pkg::KIND_ECHO;
                        pend_next.echo        = s_tdata;
                        pend_next.chan        = srgb_pkg::CHAN_NONE;
                        pend_next.level       = 16'd0;
                        pend_next.ovf         = 1'b0;
                    end
                    else
                    begin
                        // store full: drop silently and remember it
                        ovf_next = 1'b1;
                    end
                end
            end
            S_WALK:
            begin
                if (walk_issue)
                begin
                    issue_next = LEN_W'(issue_reg + 1'b1);
                    dvld_next  = 1'b1;
                end
                if (walk_step && status.stop)
                begin
                    state_next = S_FINISH;
                end
                else if (!dvld_reg && (issue_reg >= len_reg))
                begin
                    // whole line consumed
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                pend_valid_next = 1'b1;
                pend_next.kind  = srgb_pkg::KIND_LINE;
                pend_next.echo  = 8'd0;
                pend_next.chan  = status.chan;
                pend_next.level = (status.chan != srgb_pkg::CHAN_NONE) ?
                                  square_full[15:0] : 16'd0;
                pend_next.ovf   = ovf_reg;
                len_next        = '0;
                ovf_next        = 1'b0;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            len_reg        <= '0;
            ovf_reg        <= 1'b0;
            issue_reg      <= '0;
            dvld_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            len_reg        <= len_next;
            ovf_reg        <= ovf_next;
            issue_reg      <= issue_next;
            dvld_reg       <= dvld_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {5'd0, out_reg.ovf, out_reg.level, out_reg.chan, out_reg.echo};

endmodule

// ===== rtl/core/srgb_checker.sv =====
// port-level checks of the parser core and their binding to the top level
`timescale 1ns / 1ps
`include "serial_rgb_command_line_parser_core_assert.svh"

module srgb_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [7:0]                   s_tdata,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [srgb_pkg::TDATA_W-1:0] m_tdata,
    input logic [0:0]                   m_tuser
);

    // echo beats carry only the character
    `SRGB_ASSERT_IMP(a_echo_clean, m_tvalid && (m_tuser == srgb_pkg::KIND_ECHO), m_tdata[31:8] == 24'd0)

    // line beats carry no character and no level without a channel
    `SRGB_ASSERT_IMP(a_line_no_char, m_tvalid && (m_tuser == srgb_pkg::KIND_LINE), m_tdata[7:0] == 8'd0)
    `SRGB_ASSERT_IMP(a_none_zero_level, m_tvalid && (m_tdata[9:8] == srgb_pkg::CHAN_NONE), m_tdata[25:10] == 16'd0)

    // a carriage return starts the walk, input closes next cycle
    `SRGB_ASSERT_NXT(a_cr_blocks, s_tvalid && s_tready && (s_tdata == srgb_pkg::CH_CR), !s_tready)

    // stalled beat holds
    `SRGB_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind serial_rgb_command_line_parser_core srgb_checker u_srgb_checker (.*);
